// File: hw/rtl/pewq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pewq_pkg
// Shared constants, types and codes for the periodic event wait queues.
// ----------------------------------------------------------------------------
package pewq_pkg;

  localparam int NUM_DEV   = 4;
  localparam int DEV_W     = $clog2(NUM_DEV);
  localparam int MAX_TASKS = 64;
  localparam int TASK_W    = $clog2(MAX_TASKS);
  localparam int PRIO_W    = 6;
  localparam int TIME_BITS = 32;
  localparam int PERIOD_W  = 16;
  localparam int REG_IDX_W = 2;

  localparam logic [PERIOD_W-1:0] PERIOD_RST [NUM_DEV] = '{
    16'd100, 16'd200, 16'd500, 16'd50
  };

  localparam logic KIND_WAIT = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAIT,
    ST_SCAN,
    ST_DRAIN,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic                 we;
    logic [REG_IDX_W-1:0] idx;
    logic [PERIOD_W-1:0]  data;
  } cfg_wr_t;

  typedef struct packed {
    logic                 fire;
    logic [TIME_BITS-1:0] now;
  } tick_req_t;

  typedef struct packed {
    logic              fire;
    logic [DEV_W-1:0]  dev;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] prio;
  } wait_req_t;

endpackage

// File: hw/rtl/periodic_event_wait_queues.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_event_wait_queues
// Four periodic event sources with FIFO wait queues of tasks.
// ----------------------------------------------------------------------------
// Wait: busy after the transfer while the queued flag is read.
// Tick: busy for a scan state before each drained device (a single scan if none
//   drains) and a drain of its tasks; within a queue, wake transfers follow
//   one per cycle, set by the registered read of the link RAM.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
// Reset (rst_n low, synchronous): periods 100/200/500/50, match times equal
//   to the periods, all queues empty; busy after reset while the queued
//   flags are cleared.
module periodic_event_wait_queues
  import pewq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_kind,
  input  logic [DEV_W-1:0]     in_device,
  input  logic [TASK_W-1:0]    in_task_id,
  input  logic [PRIO_W-1:0]    in_task_prio,
  input  logic [TIME_BITS-1:0] in_now_ms,
  output logic                 out_valid,
  output logic [TASK_W-1:0]    out_woken_task,
  output logic [PRIO_W-1:0]    out_woken_prio,
  output logic [DEV_W-1:0]     out_from_device,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [PERIOD_W-1:0]  cfg_wdata
);

  cfg_wr_t            cfg_wr;
  tick_req_t          tick;
  wait_req_t          wait_req;
  logic [NUM_DEV-1:0] match;
  logic               accept;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign cfg_wr.we   = cfg_valid && cfg_ready;
  assign cfg_wr.idx  = cfg_index;
  assign cfg_wr.data = cfg_wdata;

  assign tick.fire = accept && (in_kind == KIND_TICK);
  assign tick.now  = in_now_ms;

  assign wait_req.fire    = accept && (in_kind == KIND_WAIT);
  assign wait_req.dev     = in_device;
  assign wait_req.task_id = in_task_id;
  assign wait_req.prio    = in_task_prio;

  pewq_timer u_timer (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .tick   (tick),
    .match  (match)
  );

  pewq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wait_req  (wait_req),
    .tick_fire (tick.fire),
    .match     (match),
    .busy      (busy),
    .out_valid (out_valid),
    .out_task  (out_woken_task),
    .out_prio  (out_woken_prio),
    .out_dev   (out_from_device),
    .out_last  (out_last)
  );

endmodule

// File: hw/rtl/pewq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pewq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pewq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/pewq_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pewq_timer
// Period registers and next match times; flags devices due at a tick.
// ----------------------------------------------------------------------------
module pewq_timer
  import pewq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_wr_t            cfg_wr,
  input  tick_req_t          tick,
  output logic [NUM_DEV-1:0] match
);

  logic [PERIOD_W-1:0]  period_r   [NUM_DEV];
  logic [TIME_BITS-1:0] match_tm_r [NUM_DEV];

  always_comb begin
    for (int d = 0; d < NUM_DEV; d++) begin
      match[d] = (match_tm_r[d] <= tick.now);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < NUM_DEV; d++) begin
        period_r[d]   <= PERIOD_RST[d];
        match_tm_r[d] <= TIME_BITS'(PERIOD_RST[d]);
      end
    end else begin
      for (int d = 0; d < NUM_DEV; d++) begin
        if (cfg_wr.we && (cfg_wr.idx == REG_IDX_W'(d))) begin
          period_r[d] <= cfg_wr.data;
        end
        if (tick.fire && match[d]) begin
          match_tm_r[d] <= tick.now + TIME_BITS'(period_r[d]);
        end
      end
    end
  end

endmodule

// File: hw/rtl/pewq_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pewq_queue
// Per-device linked task queues in RAM; append on wait, drain on tick.
// ----------------------------------------------------------------------------
module pewq_queue
  import pewq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  wait_req_t          wait_req,
  input  logic               tick_fire,
  input  logic [NUM_DEV-1:0] match,
  output logic               busy,
  output logic               out_valid,
  output logic [TASK_W-1:0]  out_task,
  output logic [PRIO_W-1:0]  out_prio,
  output logic [DEV_W-1:0]   out_dev,
  output logic               out_last
);

  state_t state_r, state_nxt;

  logic [NUM_DEV-1:0]   mask_r, mask_nxt;
  logic [DEV_W-1:0]     dev_r, dev_nxt;
  logic [TASK_W-1:0]    cur_r, cur_nxt;
  logic [TASK_W-1:0]    head_r [NUM_DEV];
  logic [TASK_W-1:0]    tail_r [NUM_DEV];
  logic [NUM_DEV-1:0]   head_vld_r;
  logic [TASK_W-1:0]    clr_r;
  logic [DEV_W-1:0]     wdev_r;
  logic [TASK_W-1:0]    wtask_r;
  logic [PRIO_W-1:0]    wprio_r;

  logic [TASK_W-1:0] rd_addr;
  logic [TASK_W-1:0] link_rdata;
  logic [PRIO_W-1:0] prio_rdata;
  logic [0:0]        q_rdata;
  logic              q_we;
  logic [TASK_W-1:0] q_waddr;
  logic [0:0]        q_wdata;
  logic              wait_ok;
  logic              link_we;
  logic              pick_any;
  logic [DEV_W-1:0]  pick_dev;
  logic              is_end;

  assign wait_ok = (state_r == ST_WAIT) && !q_rdata[0];
  assign link_we = wait_ok && head_vld_r[wdev_r];
  assign is_end  = (cur_r == tail_r[dev_r]);

  // lowest pending device first
  always_comb begin
    pick_any = 1'b0;
    pick_dev = '0;
    for (int d = NUM_DEV - 1; d >= 0; d--) begin
      if (mask_r[d]) begin
        pick_any = 1'b1;
        pick_dev = DEV_W'(d);
      end
    end
  end

  // per-task queued flag, read when a wait is taken
  pewq_ram #(.WIDTH(1), .DEPTH(MAX_TASKS)) u_queued_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (wait_req.task_id),
    .rdata (q_rdata)
  );

  pewq_ram #(.WIDTH(PRIO_W), .DEPTH(MAX_TASKS)) u_prio_ram (
    .clk   (clk),
    .we    (wait_ok),
    .waddr (wtask_r),
    .wdata (wprio_r),
    .raddr (rd_addr),
    .rdata (prio_rdata)
  );

  pewq_ram #(.WIDTH(TASK_W), .DEPTH(MAX_TASKS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (tail_r[wdev_r]),
    .wdata (wtask_r),
    .raddr (rd_addr),
    .rdata (link_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == TASK_W'(MAX_TASKS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (tick_fire) begin
          state_nxt = ST_SCAN;
        end else if (wait_req.fire) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        state_nxt = pick_any ? ST_DRAIN : ST_IDLE;
      end
      ST_DRAIN: begin
        if (is_end) begin
          state_nxt = (mask_r == '0) ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    busy      = (state_r != ST_IDLE);
    out_valid = 1'b0;
    out_last  = 1'b0;
    out_task  = cur_r;
    out_prio  = prio_rdata;
    out_dev   = dev_r;
    mask_nxt  = mask_r;
    dev_nxt   = dev_r;
    cur_nxt   = cur_r;
    rd_addr   = link_rdata;
    q_we      = 1'b0;
    q_waddr   = wtask_r;
    q_wdata   = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        q_we    = 1'b1;
        q_waddr = clr_r;
        q_wdata = 1'b0;
      end
      ST_IDLE: begin
        if (tick_fire) begin
          mask_nxt = match & head_vld_r;
        end
      end
      ST_WAIT: begin
        q_we = wait_ok;
      end
      ST_SCAN: begin
        rd_addr = head_r[pick_dev];
        if (pick_any) begin
          cur_nxt            = head_r[pick_dev];
          dev_nxt            = pick_dev;
          mask_nxt[pick_dev] = 1'b0;
        end
      end
      ST_DRAIN: begin
        out_valid = 1'b1;
        out_last  = is_end && (mask_r == '0);
        cur_nxt   = link_rdata;
        q_we      = 1'b1;
        q_waddr   = cur_r;
        q_wdata   = 1'b0;
      end
      default: begin
        mask_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      mask_r     <= '0;
      head_vld_r <= '0;
      clr_r      <= '0;
      for (int d = 0; d < NUM_DEV; d++) begin
        tail_r[d] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      mask_r  <= mask_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (wait_ok) begin
        tail_r[wdev_r]     <= wtask_r;
        head_vld_r[wdev_r] <= 1'b1;
      end
      if (state_r == ST_IDLE && tick_fire) begin
        head_vld_r <= head_vld_r & ~match;
      end
    end
  end

  always_ff @(posedge clk) begin
    dev_r <= dev_nxt;
    cur_r <= cur_nxt;
    if (wait_req.fire) begin
      wdev_r  <= wait_req.dev;
      wtask_r <= wait_req.task_id;
      wprio_r <= wait_req.prio;
    end
    if (wait_ok && !head_vld_r[wdev_r]) begin
      head_r[wdev_r] <= wtask_r;
    end
  end

endmodule
